@@ src/pps_pkg.sv @@
`timescale 1ns / 1ps
// Package for the preemptive priority scheduler: sizes, FSM state type and
// the command/status structs between controller and datapath. No dependencies.
package pps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  localparam int PRI_W   = 8;
  localparam int TIME_W  = 16;
  localparam int TICK_W  = 21;
  localparam int TOTAL_W = 25;
  localparam int PNUM_W  = 4;

  localparam int IN_W  = 40;
  localparam int OUT_W = 120;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic clr_best;
    logic idx_clr;
    logic scan;
    logic update;
    logic out_load;
    logic clr_batch;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic idx_last;
    logic all_done;
    logic out_free;
  } status_t;

endpackage

@@ src/pps_ctrl.sv @@
`timescale 1ns / 1ps
// Scheduler controller: load, per-tick scan/update loop and result emission.
// Depends on pps_pkg.
module pps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  pps_pkg::status_t status,
  output pps_pkg::cmd_t    cmd
);

  pps_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pps_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      pps_pkg::ST_LOAD: begin
        cmd.accept = 1'b1;
        if (status.in_fire && status.in_last) begin
          state_next = pps_pkg::ST_CHECK;
        end
      end
      pps_pkg::ST_CHECK: begin
        cmd.clr_best = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_next = status.all_done ? pps_pkg::ST_OUT : pps_pkg::ST_SCAN;
      end
      pps_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.idx_last) begin
          state_next = pps_pkg::ST_UPDATE;
        end
      end
      pps_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = pps_pkg::ST_CHECK;
      end
      pps_pkg::ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_last) begin
            cmd.clr_batch = 1'b1;
            state_next = pps_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_next = pps_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ src/pps_datapath.sv @@
`timescale 1ns / 1ps
// Scheduler datapath: process stores, tick counter, best-candidate scan
// registers, result arithmetic and output register. Depends on pps_pkg.
module pps_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  pps_pkg::cmd_t                 cmd,
  output pps_pkg::status_t              status,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [pps_pkg::IN_W-1:0]      s_tdata,
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [pps_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tlast
);

  localparam int IW = pps_pkg::IDX_W;
  localparam int CW = pps_pkg::CNT_W;
  localparam int N  = pps_pkg::MAX_PROCS;

  logic [pps_pkg::PRI_W-1:0]  pri_mem  [N];
  logic [pps_pkg::TIME_W-1:0] arr_mem  [N];
  logic [pps_pkg::TIME_W-1:0] bst_mem  [N];
  logic [pps_pkg::TIME_W-1:0] rem_mem  [N];
  logic [pps_pkg::TICK_W-1:0] comp_mem [N];
  logic [N-1:0]               fin;

  logic [CW-1:0] count;
  logic [CW-1:0] fin_cnt;
  logic [pps_pkg::TICK_W-1:0] tick;
  logic [IW-1:0] idx;

  logic                       best_valid;
  logic [IW-1:0]              best_idx;
  logic [pps_pkg::PRI_W-1:0]  best_pri;
  logic [pps_pkg::TIME_W-1:0] best_arr;

  logic [pps_pkg::TOTAL_W-1:0] tot_tat, tot_wt;

  logic                       in_fire, store_ok;
  logic [pps_pkg::PRI_W-1:0]  in_pri;
  logic [pps_pkg::TIME_W-1:0] in_arr, in_bst;

  logic [pps_pkg::PRI_W-1:0]  rd_pri;
  logic [pps_pkg::TIME_W-1:0] rd_arr, rd_bst, rd_rem, rem_dec;
  logic                       rd_ready, better;
  logic [pps_pkg::TICK_W-1:0] tick_inc, rd_ct, tat, wt;
  logic [pps_pkg::TOTAL_W-1:0] tot_tat_next, tot_wt_next;
  logic                       out_free;

  assign in_pri = s_tdata[7:0];
  assign in_arr = s_tdata[23:8];
  assign in_bst = s_tdata[39:24];

  assign s_tready = cmd.accept;
  assign in_fire  = s_tvalid && cmd.accept;
  assign store_ok = count < CW'(N);

  assign rd_pri   = pri_mem[idx];
  assign rd_arr   = arr_mem[idx];
  assign rd_bst   = bst_mem[idx];
  assign rd_ct    = comp_mem[idx];
  assign rd_rem   = rem_mem[best_idx];
  assign rem_dec  = (rd_rem == '0) ? rd_rem : rd_rem - 1'b1;
  assign tick_inc = tick + 1'b1;

  assign rd_ready = !fin[idx] && (tick >= pps_pkg::TICK_W'(rd_arr));
  assign better   = !best_valid || (rd_pri > best_pri) ||
                    ((rd_pri == best_pri) && (rd_arr < best_arr));

  assign tat = rd_ct - pps_pkg::TICK_W'(rd_arr);
  assign wt  = tat - pps_pkg::TICK_W'(rd_bst);
  assign tot_tat_next = tot_tat + pps_pkg::TOTAL_W'(tat);
  assign tot_wt_next  = tot_wt + pps_pkg::TOTAL_W'(wt);

  assign out_free = !m_tvalid || m_tready;

  assign status.in_fire  = in_fire;
  assign status.in_last  = s_tlast;
  assign status.idx_last = (CW'(idx) + 1'b1) == count;
  assign status.all_done = fin_cnt == count;
  assign status.out_free = out_free;

  // stores: written on load, updated per tick
  always_ff @(posedge clk) begin
    if (in_fire && store_ok) begin
      pri_mem[count[IW-1:0]] <= in_pri;
      arr_mem[count[IW-1:0]] <= in_arr;
      bst_mem[count[IW-1:0]] <= in_bst;
      rem_mem[count[IW-1:0]] <= in_bst;
    end
    if (cmd.update && best_valid) begin
      rem_mem[best_idx] <= rem_dec;
      if (rem_dec == '0) begin
        comp_mem[best_idx] <= tick_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_batch) begin
      fin     <= '0;
      count   <= '0;
      fin_cnt <= '0;
      tick    <= '0;
    end else begin
      if (in_fire && store_ok) begin
        fin[count[IW-1:0]] <= 1'b0;
        count <= count + 1'b1;
      end
      if (cmd.update) begin
        tick <= tick_inc;
        if (best_valid && (rem_dec == '0)) begin
          fin[best_idx] <= 1'b1;
          fin_cnt <= fin_cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.scan || cmd.out_load) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_best) begin
      best_valid <= 1'b0;
    end else if (cmd.scan && rd_ready && better) begin
      best_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && rd_ready && better) begin
      best_idx <= idx;
      best_pri <= rd_pri;
      best_arr <= rd_arr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_batch) begin
      tot_tat <= '0;
      tot_wt  <= '0;
    end else if (cmd.out_load) begin
      tot_tat <= tot_tat_next;
      tot_wt  <= tot_wt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {3'b000, tot_wt_next, tot_tat_next, wt, tat, rd_ct,
                  pps_pkg::PNUM_W'(idx)};
      m_tlast <= status.idx_last;
    end
  end

endmodule

@@ src/preemptive_priority_scheduler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the preemptive priority scheduler: controller plus datapath.
// Depends on pps_pkg, pps_ctrl and pps_datapath.
//
// Channel  Dir  Payload
// s_*      in   tdata: priority_req[7:0], arrival_time[23:8], burst_time[39:24];
//               tlast: last_process
// m_*      out  tdata: process_number, completion, turnaround, waiting,
//               total_turnaround, total_waiting, 3 zero pad; tlast: last_result
//
// Loading takes one item per cycle. After the last item, each simulated tick
// runs a check, a sequential scan of the stores and one update; once all
// processes have finished, one result per process is emitted.
// No item is accepted from the last item until the final result is loaded.
// Results leave through an output register; m_tready low stalls the emission.
// rst is synchronous and returns the block to an empty batch.
module preemptive_priority_scheduler_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // priority_req[7:0], arrival_time[23:8], burst_time[39:24]
  input  logic [pps_pkg::IN_W-1:0]  s_tdata,
  input  logic                      s_tlast,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // process_number[3:0], completion_time[24:4], turnaround_time[45:25],
  // waiting_time[66:46], total_turnaround[91:67], total_waiting[116:92]
  output logic [pps_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);

  pps_pkg::cmd_t    cmd;
  pps_pkg::status_t status;

  pps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  pps_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
